@@ rtl/box_merge_and_plate_select_core_defines.svh @@
// assertion macros for the box merge and plate select core
// used by files that check their own logic; needs clk_i and rst_ni in scope
`ifndef BOX_MERGE_AND_PLATE_SELECT_CORE_DEFINES_SVH
`define BOX_MERGE_AND_PLATE_SELECT_CORE_DEFINES_SVH

// check on every edge outside reset
`define BMPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check on every edge, also during reset
`define BMPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/bmps_pkg.sv @@
// shared types and constants of the box merge and plate select core
// no dependencies
package bmps_pkg;

  localparam int MAX_BOXES_DEF  = 64;
  localparam int COORD_BITS_DEF = 12;
  localparam int CFG_W          = 24;
  localparam int BOUND_W        = 12;
  localparam int CFG_IDX_W      = 3;

  // register reset values
  localparam logic [CFG_W-1:0]   FIRST_MIN_RST  = 24'd438;
  localparam logic [CFG_W-1:0]   SECOND_MIN_RST = 24'd1536;
  localparam logic [CFG_W-1:0]   MAX_AREA_RST   = 24'd30720;
  localparam logic [BOUND_W-1:0] LEFT_RST       = 12'd64;
  localparam logic [BOUND_W-1:0] RIGHT_RST      = 12'd576;
  localparam logic [BOUND_W-1:0] TOP_RST        = 12'd96;

  // merge and shape constants
  localparam int MERGE_GAP  = 10;
  localparam int CENTER_TOL = 16;
  localparam int HEIGHT_TOL = 12;
  localparam int ASP_LO_W   = 2;
  localparam int ASP_LO_H   = 5;
  localparam int ASP_HI_W   = 10;
  localparam int ASP_HI_H   = 59;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_MIN  = 3'd0,
    CFG_SECOND_MIN = 3'd1,
    CFG_MAX_AREA   = 3'd2,
    CFG_LEFT       = 3'd3,
    CFG_RIGHT      = 3'd4,
    CFG_TOP        = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_P_INIT, ST_A_FIND, ST_A_WAIT, ST_B_FIND, ST_B_WAIT,
    ST_S_INIT, ST_S_FIND, ST_S_WAIT, ST_S_CHK, ST_S_END
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic pass_init;
    logic pass_done;
    logic i_inc;
    logic rd_a;
    logic a_latch;
    logic j_inc;
    logic rd_b;
    logic keep_a;
    logic try_b;
    logic sel_init;
    logic s_latch;
    logic s_take;
    logic emit_end;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic i_end;
    logic i_removed;
    logic j_end;
    logic j_removed;
    logic merge_hit;
    logic any;
    logic sel_ok;
    logic pend_valid;
    logic push_ok;
  } sts_t;

endpackage

@@ rtl/box_merge_and_plate_select_core.sv @@
// box merge and plate select core, top level; depends on bmps_pkg, bmps_ctrl, bmps_dp
// loads may follow back to back; a finish walks the store: each merge pass reads
// box A, then compares it against each later box B (quadratic in box count, one
// store read port), selection reads, latches and checks each box, and results
// drain through one output register; async active-low reset clears control,
// stores need no clearing
module box_merge_and_plate_select_core import bmps_pkg::*; #(
  parameter int MAX_BOXES  = MAX_BOXES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [COORD_BITS-1:0] box_x_i,
  input  logic [COORD_BITS-1:0] box_y_i,
  input  logic [COORD_BITS-1:0] box_w_i,
  input  logic [COORD_BITS-1:0] box_h_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] out_x_o,
  output logic [COORD_BITS-1:0] out_y_o,
  output logic [COORD_BITS:0]   out_w_o,
  output logic [COORD_BITS-1:0] out_h_o,
  output logic                  found_o,
  output logic                  last_o,
  output logic                  dropped_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // configuration writes always land at once
  assign cfg_ready_o = 1'b1;

  bmps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bmps_dp #(
    .MAX_BOXES  (MAX_BOXES),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .box_x_i     (box_x_i),
    .box_y_i     (box_y_i),
    .box_w_i     (box_w_i),
    .box_h_i     (box_h_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_w_o     (out_w_o),
    .out_h_o     (out_h_o),
    .found_o     (found_o),
    .last_o      (last_o),
    .dropped_o   (dropped_o)
  );

endmodule

@@ rtl/bmps_ctrl.sv @@
// controller state machine of the box merge and plate select core
// depends on bmps_pkg
module bmps_ctrl import bmps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic mode_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (mode_i) begin
            state_d = ST_P_INIT;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_P_INIT: begin
        cmd_o.pass_init = 1'b1;
        state_d         = ST_A_FIND;
      end
      ST_A_FIND: begin
        if (sts_i.i_end) begin
          cmd_o.pass_done = 1'b1;
          state_d         = sts_i.any ? ST_P_INIT : ST_S_INIT;
        end else if (sts_i.i_removed) begin
          cmd_o.i_inc = 1'b1;
        end else begin
          cmd_o.rd_a = 1'b1;
          state_d    = ST_A_WAIT;
        end
      end
      ST_A_WAIT: begin
        cmd_o.a_latch = 1'b1;
        state_d       = ST_B_FIND;
      end
      ST_B_FIND: begin
        if (sts_i.j_end) begin
          cmd_o.keep_a = 1'b1;
          state_d      = ST_A_FIND;
        end else if (sts_i.j_removed) begin
          cmd_o.j_inc = 1'b1;
        end else begin
          cmd_o.rd_b = 1'b1;
          state_d    = ST_B_WAIT;
        end
      end
      ST_B_WAIT: begin
        cmd_o.try_b = 1'b1;
        state_d     = sts_i.merge_hit ? ST_A_FIND : ST_B_FIND;
      end
      ST_S_INIT: begin
        cmd_o.sel_init = 1'b1;
        state_d        = ST_S_FIND;
      end
      ST_S_FIND: begin
        if (sts_i.i_end) begin
          state_d = ST_S_END;
        end else begin
          cmd_o.rd_a = 1'b1;
          state_d    = ST_S_WAIT;
        end
      end
      ST_S_WAIT: begin
        cmd_o.s_latch = 1'b1;
        state_d       = ST_S_CHK;
      end
      ST_S_CHK: begin
        if (!sts_i.sel_ok) begin
          cmd_o.i_inc = 1'b1;
          state_d     = ST_S_FIND;
        end else if (!sts_i.pend_valid || sts_i.push_ok) begin
          cmd_o.s_take = 1'b1;
          state_d      = ST_S_FIND;
        end
      end
      ST_S_END: begin
        if (sts_i.push_ok) begin
          cmd_o.emit_end = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/bmps_dp.sv @@
// datapath of the box merge and plate select core: registers, box stores,
// merge and selection logic, output register; depends on bmps_pkg and the defines header
`include "box_merge_and_plate_select_core_defines.svh"
module bmps_dp import bmps_pkg::*; #(
  parameter int MAX_BOXES  = MAX_BOXES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  logic                    cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic [COORD_BITS-1:0]   box_x_i,
  input  logic [COORD_BITS-1:0]   box_y_i,
  input  logic [COORD_BITS-1:0]   box_w_i,
  input  logic [COORD_BITS-1:0]   box_h_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [COORD_BITS-1:0]   out_x_o,
  output logic [COORD_BITS-1:0]   out_y_o,
  output logic [COORD_BITS:0]     out_w_o,
  output logic [COORD_BITS-1:0]   out_h_o,
  output logic                    found_o,
  output logic                    last_o,
  output logic                    dropped_o
);

  localparam int CW   = COORD_BITS;
  localparam int IW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int NW   = $clog2(MAX_BOXES + 1);
  localparam int BW   = 4 * CW;
  localparam int AW   = (2 * CW > CFG_W) ? 2 * CW : CFG_W;
  localparam int PW   = (CW + 1 > BOUND_W) ? CW + 1 : BOUND_W;
  localparam int RW   = CW + 7;

  // configuration registers
  logic [CFG_W-1:0]   first_min_q, second_min_q, max_area_q;
  logic [BOUND_W-1:0] left_q, right_q, top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_min_q  <= FIRST_MIN_RST;
      second_min_q <= SECOND_MIN_RST;
      max_area_q   <= MAX_AREA_RST;
      left_q       <= LEFT_RST;
      right_q      <= RIGHT_RST;
      top_q        <= TOP_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FIRST_MIN:  first_min_q  <= cfg_data_i;
        CFG_SECOND_MIN: second_min_q <= cfg_data_i;
        CFG_MAX_AREA:   max_area_q   <= cfg_data_i;
        CFG_LEFT:       left_q       <= cfg_data_i[BOUND_W-1:0];
        CFG_RIGHT:      right_q      <= cfg_data_i[BOUND_W-1:0];
        CFG_TOP:        top_q        <= cfg_data_i[BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  // control counters and flags
  logic [NW-1:0]        count_q, n_q, i_q, j_q, kept_q;
  logic                 ovf_q, any_q, cur_q, pend_valid_q;
  logic [MAX_BOXES-1:0] removed_q;

  // load filter
  logic [AW-1:0] ld_area;
  logic          ld_pass;
  assign ld_area = AW'(box_w_i) * AW'(box_h_i);
  assign ld_pass = (ld_area > AW'(first_min_q)) && (ld_area < AW'(max_area_q)) &&
                   (PW'(box_x_i) > PW'(left_q)) &&
                   (PW'(box_x_i) + PW'(box_w_i) < PW'(right_q)) &&
                   (PW'(box_y_i) > PW'(top_q));

  // read data and box A register
  logic [BW-1:0] rd0_q, rd1_q, rdata;
  logic [CW-1:0] ax_q, ay_q, aw_q, ah_q;
  logic [CW-1:0] bx, by, bw, bh;
  assign rdata = cur_q ? rd1_q : rd0_q;
  assign {bx, by, bw, bh} = rdata;

  // merge test of A against B
  logic [CW:0]   a_end, b_end, bx_e, ax_e;
  logic [CW+1:0] ca, cb, dc;
  logic [CW-1:0] dh;
  logic          on_right, on_left, nr_ab, nr_ba, merge_hit;
  logic [CW-1:0] mx, my, mw, mh;
  assign ax_e   = {1'b0, ax_q};
  assign bx_e   = {1'b0, bx};
  assign a_end  = ax_e + {1'b0, aw_q};
  assign b_end  = bx_e + {1'b0, bw};
  assign nr_ab  = ((bx_e >= a_end) && (bx_e - a_end <= (CW+1)'(MERGE_GAP))) ||
                  ((bx_e <= a_end) && (b_end > a_end));
  assign nr_ba  = ((ax_e >= b_end) && (ax_e - b_end <= (CW+1)'(MERGE_GAP))) ||
                  ((ax_e <= b_end) && (a_end > b_end));
  assign on_right = bx > ax_q;
  assign on_left  = ax_q > bx;
  // doubled vertical centers
  assign ca     = {1'b0, ay_q, 1'b0} + (CW+2)'(ah_q);
  assign cb     = {1'b0, by, 1'b0} + (CW+2)'(bh);
  assign dc     = (cb >= ca) ? cb - ca : ca - cb;
  assign dh     = (bh >= ah_q) ? bh - ah_q : ah_q - bh;
  assign merge_hit = ((on_right && nr_ab) || (on_left && nr_ba)) &&
                     (dc <= (CW+2)'(CENTER_TOL)) && (dh < CW'(HEIGHT_TOL));
  assign mx = on_right ? ax_q : bx;
  assign mw = on_right ? CW'(b_end - ax_e) : CW'(a_end - bx_e);
  assign my = (by > ay_q) ? ay_q : by;
  assign mh = (bh > ah_q) ? bh : ah_q;

  // store write port
  logic          ld_wr, mg_wr, we0, we1;
  logic [IW-1:0] wa, ra;
  logic [BW-1:0] wd;
  assign ld_wr = cmd_i.load && ld_pass && (count_q < NW'(MAX_BOXES));
  assign mg_wr = cmd_i.keep_a || (cmd_i.try_b && merge_hit);
  assign wa    = ld_wr ? count_q[IW-1:0] : kept_q[IW-1:0];
  assign wd    = ld_wr ? {box_x_i, box_y_i, box_w_i, box_h_i} :
                 cmd_i.keep_a ? {ax_q, ay_q, aw_q, ah_q} : {mx, my, mw, mh};
  assign we0   = (ld_wr && !cur_q) || (mg_wr && cur_q);
  assign we1   = (ld_wr && cur_q) || (mg_wr && !cur_q);
  assign ra    = cmd_i.rd_b ? j_q[IW-1:0] : i_q[IW-1:0];

  // two box banks, one holds the current list, the other takes a pass result
  logic [BW-1:0] mem0 [MAX_BOXES];
  logic [BW-1:0] mem1 [MAX_BOXES];

  always_ff @(posedge clk_i) begin
    if (we0) begin
      mem0[wa] <= wd;
    end
    if (cmd_i.rd_a || cmd_i.rd_b) begin
      rd0_q <= mem0[ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we1) begin
      mem1[wa] <= wd;
    end
    if (cmd_i.rd_a || cmd_i.rd_b) begin
      rd1_q <= mem1[ra];
    end
  end

  // box A and selection candidate registers
  logic [CW-1:0]   cx_q, cy_q, cw_q, ch_q;
  logic [2*CW-1:0] area_q;
  logic [CW-1:0]   px_q, py_q, pw_q, ph_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.a_latch) begin
      {ax_q, ay_q, aw_q, ah_q} <= rdata;
    end
    if (cmd_i.s_latch) begin
      {cx_q, cy_q, cw_q, ch_q} <= rdata;
      area_q <= (2*CW)'(bw) * (2*CW)'(bh);
    end
    if (cmd_i.s_take) begin
      {px_q, py_q, pw_q, ph_q} <= {cx_q, cy_q, cw_q, ch_q};
    end
  end

  // plate shape test
  logic sel_ok;
  assign sel_ok = (AW'(area_q) > AW'(second_min_q)) && (AW'(area_q) < AW'(max_area_q)) &&
                  (PW'(cy_q) > PW'(top_q)) &&
                  (RW'(cw_q) * RW'(ASP_LO_W) > RW'(ch_q) * RW'(ASP_LO_H)) &&
                  (RW'(cw_q) * RW'(ASP_HI_W) < RW'(ch_q) * RW'(ASP_HI_H));

  // counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      n_q          <= '0;
      i_q          <= '0;
      j_q          <= '0;
      kept_q       <= '0;
      ovf_q        <= 1'b0;
      any_q        <= 1'b0;
      cur_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      removed_q    <= '0;
    end else begin
      if (ld_wr) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.load && ld_pass) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.pass_init) begin
        n_q       <= count_q;
        i_q       <= '0;
        kept_q    <= '0;
        any_q     <= 1'b0;
        removed_q <= '0;
      end
      if (cmd_i.pass_done) begin
        count_q <= kept_q;
        cur_q   <= ~cur_q;
      end
      if (cmd_i.i_inc || cmd_i.keep_a || cmd_i.s_take || (cmd_i.try_b && merge_hit)) begin
        i_q <= i_q + 1'b1;
      end
      if (cmd_i.a_latch) begin
        j_q <= i_q + 1'b1;
      end
      if (cmd_i.j_inc || (cmd_i.try_b && !merge_hit)) begin
        j_q <= j_q + 1'b1;
      end
      if (mg_wr) begin
        kept_q <= kept_q + 1'b1;
      end
      if (cmd_i.try_b && merge_hit) begin
        removed_q[j_q[IW-1:0]] <= 1'b1;
        any_q                  <= 1'b1;
      end
      if (cmd_i.sel_init) begin
        n_q          <= count_q;
        i_q          <= '0;
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.s_take) begin
        pend_valid_q <= 1'b1;
      end
      if (cmd_i.emit_end) begin
        count_q      <= '0;
        ovf_q        <= 1'b0;
        pend_valid_q <= 1'b0;
      end
    end
  end

  // output register
  logic push, push_ok, out_valid_q;
  assign push_ok = !out_valid_q || !out_stall_i;
  assign push    = cmd_i.emit_end || (cmd_i.s_take && pend_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      if (pend_valid_q) begin
        out_x_o <= px_q;
        out_y_o <= py_q;
        out_w_o <= {1'b0, pw_q};
        out_h_o <= ph_q;
      end else begin
        out_x_o <= '0;
        out_y_o <= '0;
        out_w_o <= '0;
        out_h_o <= '0;
      end
      found_o   <= pend_valid_q;
      last_o    <= cmd_i.emit_end;
      dropped_o <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // status
  assign sts_o.i_end      = (i_q == n_q);
  assign sts_o.i_removed  = removed_q[i_q[IW-1:0]];
  assign sts_o.j_end      = (j_q == n_q);
  assign sts_o.j_removed  = removed_q[j_q[IW-1:0]];
  assign sts_o.merge_hit  = merge_hit;
  assign sts_o.any        = any_q;
  assign sts_o.sel_ok     = sel_ok;
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.push_ok    = push_ok;

  `BMPS_ASSERT_ALWAYS(a_count_range, count_q <= NW'(MAX_BOXES), "box count beyond store depth")
  `BMPS_ASSERT(a_kept_le_n, kept_q <= n_q, "pass wrote more boxes than it read")
  `BMPS_ASSERT(a_push_free, push |-> push_ok, "result pushed over a held result")

endmodule
